// ===== hdl/gwc_pkg.sv =====
`timescale 1ns / 1ps
package gwc_pkg;

  // default build parameters
  localparam int KernelSizeDef = 3;
  localparam int ChannelsDef   = 3;
  localparam int MaxWidthDef   = 1024;

  // queue depths (powers of two)
  localparam int CmdDepth = 4;
  localparam int OutDepth = 8;

  // configuration register indexes
  localparam logic [7:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_IMAGE_HEIGHT = 8'd1;
  localparam logic [7:0] CFG_COEFF_D0     = 8'd2;
  localparam logic [7:0] CFG_COEFF_D1     = 8'd3;
  localparam logic [7:0] CFG_COEFF_D2     = 8'd4;
  localparam logic [7:0] CFG_COEFF_D4     = 8'd5;
  localparam logic [7:0] CFG_COEFF_D5     = 8'd6;
  localparam logic [7:0] CFG_COEFF_D8     = 8'd7;

  // register reset values
  localparam logic [10:0] WidthRst  = 11'd640;
  localparam logic [15:0] HeightRst = 16'd480;
  localparam logic [15:0] CoeffD0Rst = 16'd15952;
  localparam logic [15:0] CoeffD1Rst = 16'd8190;
  localparam logic [15:0] CoeffD2Rst = 16'd4206;
  localparam logic [15:0] CoeffD4Rst = 16'd0;
  localparam logic [15:0] CoeffD5Rst = 16'd0;
  localparam logic [15:0] CoeffD8Rst = 16'd0;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [15:0] d0;
    logic [15:0] d1;
    logic [15:0] d2;
    logic [15:0] d4;
    logic [15:0] d5;
    logic [15:0] d8;
  } coeffs_t;

  // classification of one item, front to back
  typedef struct packed {
    logic       wr;
    logic       emit;
    logic       interior;
    logic       frame_end;
    logic [7:0] sample;
  } cmd_ctrl_t;

  // weight by squared distance from the window centre
  function automatic logic [15:0] weight_sel(input int d2, input coeffs_t c);
    logic [15:0] w;
    case (d2)
      0: w = c.d0;
      1: w = c.d1;
      2: w = c.d2;
      4: w = c.d4;
      5: w = c.d5;
      8: w = c.d8;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/gwc_fifo.sv =====
`timescale 1ns / 1ps
module gwc_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign rdata_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i) rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

// ===== hdl/gwc_front.sv =====
`timescale 1ns / 1ps
module gwc_front #(
  parameter int KERNEL_SIZE = gwc_pkg::KernelSizeDef,
  parameter int CHANNELS    = gwc_pkg::ChannelsDef,
  parameter int MAX_WIDTH   = gwc_pkg::MaxWidthDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  gwc_pkg::in_item_t                          in_item_i,
  input  logic [10:0]                                cfg_width_i,
  input  logic [15:0]                                cfg_height_i,
  input  logic                                       cmd_ready_i,
  output logic                                       cmd_push_o,
  output gwc_pkg::cmd_ctrl_t                         cmd_ctrl_o,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] cmd_ch_o,
  output logic [$clog2(MAX_WIDTH*CHANNELS)-1:0]      cmd_addr_o
);

  localparam int OFF = KERNEL_SIZE / 2;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = $clog2(MAX_WIDTH * CHANNELS);
  localparam logic [CHW-1:0] ChLast = CHW'(CHANNELS - 1);
  localparam logic [WW:0]    OffC   = (WW+1)'(OFF);
  localparam logic [16:0]    OffR   = 17'(OFF);

  logic [CHW-1:0] i_ch_q, o_ch_q;
  logic [WW-1:0]  i_col_q, o_col_q, fw_q, fw, eff_w;
  logic [15:0]    i_row_q, o_row_q, fh_q, fh, eff_h;
  logic [AW-1:0]  i_pos_q;
  logic [31:0]    w32;
  logic           accept, start, all_in, is_write, emit, in_late, interior, fend;
  logic           i_ch_last, i_col_last, o_ch_last, o_col_last;

  always_comb begin
    w32 = 32'(cfg_width_i);
    if (w32 < 32'd3) eff_w = WW'(3);
    else if (w32 > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(w32);
    eff_h = (cfg_height_i < 16'd3) ? 16'd3 : cfg_height_i;
  end

  assign start = (i_ch_q == '0) && (i_col_q == '0) && (i_row_q == '0) &&
                 (o_ch_q == '0) && (o_col_q == '0) && (o_row_q == '0);
  assign fw = start ? eff_w : fw_q;
  assign fh = start ? eff_h : fh_q;

  assign all_in   = (i_row_q == fh);
  assign is_write = !all_in && (in_item_i.req_type == gwc_pkg::REQ_SAMPLE);
  // output starts once the sample OFF rows and OFF columns ahead is in
  assign in_late  = (17'(i_row_q) > OffR) ||
                    ((17'(i_row_q) == OffR) && ({1'b0, i_col_q} >= OffC));
  assign emit     = all_in || (is_write && in_late);

  assign interior = (17'(o_row_q) >= OffR) && (17'(o_row_q) + OffR < 17'(fh)) &&
                    ({1'b0, o_col_q} >= OffC) && ({1'b0, o_col_q} + OffC < {1'b0, fw});

  assign i_ch_last  = (i_ch_q == ChLast);
  assign i_col_last = (i_col_q == fw - WW'(1));
  assign o_ch_last  = (o_ch_q == ChLast);
  assign o_col_last = (o_col_q == fw - WW'(1));
  assign fend = emit && o_ch_last && o_col_last && (o_row_q == fh - 16'd1);

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign cmd_push_o = accept && (is_write || emit);

  assign cmd_ctrl_o = '{wr: is_write, emit: emit, interior: interior,
                        frame_end: fend, sample: in_item_i.sample};
  assign cmd_ch_o   = i_ch_q;
  assign cmd_addr_o = i_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_ch_q  <= '0;
      i_col_q <= '0;
      i_row_q <= '0;
      i_pos_q <= '0;
      o_ch_q  <= '0;
      o_col_q <= '0;
      o_row_q <= '0;
      fw_q    <= WW'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
      fh_q    <= gwc_pkg::HeightRst;
    end else if (accept) begin
      fw_q <= fw;
      fh_q <= fh;
      if (fend) begin
        i_ch_q  <= '0;
        i_col_q <= '0;
        i_row_q <= '0;
        i_pos_q <= '0;
        o_ch_q  <= '0;
        o_col_q <= '0;
        o_row_q <= '0;
      end else begin
        if (is_write) begin
          if (i_ch_last) begin
            i_ch_q <= '0;
            if (i_col_last) begin
              i_col_q <= '0;
              i_row_q <= i_row_q + 16'd1;
              i_pos_q <= '0;
            end else begin
              i_col_q <= i_col_q + WW'(1);
              i_pos_q <= i_pos_q + AW'(1);
            end
          end else begin
            i_ch_q  <= i_ch_q + CHW'(1);
            i_pos_q <= i_pos_q + AW'(1);
          end
        end
        if (emit) begin
          if (o_ch_last) begin
            o_ch_q <= '0;
            if (o_col_last) begin
              o_col_q <= '0;
              o_row_q <= o_row_q + 16'd1;
            end else begin
              o_col_q <= o_col_q + WW'(1);
            end
          end else begin
            o_ch_q <= o_ch_q + CHW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== hdl/gwc_back.sv =====
`timescale 1ns / 1ps
module gwc_back #(
  parameter int KERNEL_SIZE = gwc_pkg::KernelSizeDef,
  parameter int CHANNELS    = gwc_pkg::ChannelsDef,
  parameter int MAX_WIDTH   = gwc_pkg::MaxWidthDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cmd_valid_i,
  output logic                                       cmd_pop_o,
  input  gwc_pkg::cmd_ctrl_t                         cmd_ctrl_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] cmd_ch_i,
  input  logic [$clog2(MAX_WIDTH*CHANNELS)-1:0]      cmd_addr_i,
  input  gwc_pkg::coeffs_t                           coeffs_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output gwc_pkg::out_item_t                         out_item_o
);

  localparam int K     = KERNEL_SIZE;
  localparam int OFF   = K / 2;
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = $clog2(MAX_WIDTH * CHANNELS);
  localparam int LDEP  = MAX_WIDTH * CHANNELS;
  localparam int RDEP  = OFF * (MAX_WIDTH + 1) * CHANNELS + 1;
  localparam int RW    = $clog2(RDEP);
  localparam int OCW   = $clog2(gwc_pkg::OutDepth + 1);
  localparam int OW    = $bits(gwc_pkg::out_item_t);

  // ring of recent samples for border pass-through
  logic [7:0]    ring_mem [RDEP];
  logic [RW-1:0] wp_q, rp_q;

  logic [7:0] line_rd_q [K-1];

  logic                  v1_q, v2_q, v3_q, v4_q;
  gwc_pkg::cmd_ctrl_t    ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [CHW-1:0]        ch1_q;
  logic [AW-1:0]         a1_q;
  logic [7:0]            pass1_q, pass2_q, pass3_q, pass4_q;
  logic [7:0]            win_q [CHANNELS][K][K];
  logic [7:0]            nwin [K][K];
  logic [7:0]            colv [K];
  logic [7:0]            taps_q [K][K];
  logic [15:0]           wt [K][K];
  logic [23:0]           prod_q [K][K];
  logic [26:0]           row_d [K];
  logic [26:0]           row_q [K];
  logic [29:0]           total;
  logic [7:0]            sat;
  logic [OCW-1:0]        ocount;
  logic [OCW:0]          inflight;
  logic                  push, ofull, oempty;
  gwc_pkg::out_item_t    res;
  logic [OW-1:0]         ordata;

  // credit check keeps the queue from filling past its depth
  assign inflight  = (OCW+1)'(ocount) + (OCW+1)'(v1_q) + (OCW+1)'(v2_q) +
                     (OCW+1)'(v3_q) + (OCW+1)'(v4_q);
  assign cmd_pop_o = cmd_valid_i && (inflight < (OCW+1)'(gwc_pkg::OutDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (cmd_pop_o && cmd_ctrl_i.wr) wp_q <= (wp_q == RW'(RDEP - 1)) ? '0 : wp_q + RW'(1);
      if (cmd_pop_o && cmd_ctrl_i.emit) rp_q <= (rp_q == RW'(RDEP - 1)) ? '0 : rp_q + RW'(1);
      v1_q <= cmd_pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_ctrl_i.wr) ring_mem[wp_q] <= cmd_ctrl_i.sample;
    if (cmd_pop_o && cmd_ctrl_i.emit) pass1_q <= ring_mem[rp_q];
  end

  // line stores: line k holds the row k+1 above the incoming one
  for (genvar k = 0; k < K - 1; k++) begin : g_line
    logic [7:0] line_mem [LDEP];
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (cmd_pop_o && cmd_ctrl_i.wr) begin
          line_rd_q[k]         <= line_mem[cmd_addr_i];
          line_mem[cmd_addr_i] <= cmd_ctrl_i.sample;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (cmd_pop_o && cmd_ctrl_i.wr) line_rd_q[k] <= line_mem[cmd_addr_i];
        if (v1_q && ctrl1_q.wr) line_mem[a1_q] <= line_rd_q[k-1];
      end
    end
  end

  // new column enters at the right of the channel's window
  always_comb begin
    colv[K-1] = ctrl1_q.sample;
    for (int k = 0; k < K - 1; k++) colv[K-2-k] = line_rd_q[k];
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K - 1; j++) nwin[i][j] = win_q[ch1_q][i][j+1];
      nwin[i][K-1] = colv[i];
    end
  end

  for (genvar i = 0; i < K; i++) begin : g_wr
    for (genvar j = 0; j < K; j++) begin : g_wc
      localparam int DY = (i > OFF) ? i - OFF : OFF - i;
      localparam int DX = (j > OFF) ? j - OFF : OFF - j;
      assign wt[i][j] = gwc_pkg::weight_sel(DX * DX + DY * DY, coeffs_i);
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < K; j++) row_d[i] = row_d[i] + 27'(prod_q[i][j]);
    end
    total = '0;
    for (int i = 0; i < K; i++) total = total + 30'(row_q[i]);
    sat = (total[29:24] != '0) ? 8'hFF : total[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ctrl1_q.wr) win_q[ch1_q] <= nwin;
    if (cmd_pop_o) begin
      ctrl1_q <= cmd_ctrl_i;
      ch1_q   <= cmd_ch_i;
      a1_q    <= cmd_addr_i;
    end
    ctrl2_q <= ctrl1_q;
    pass2_q <= pass1_q;
    taps_q  <= nwin;
    ctrl3_q <= ctrl2_q;
    pass3_q <= pass2_q;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) prod_q[i][j] <= 24'(taps_q[i][j]) * 24'(wt[i][j]);
    end
    ctrl4_q <= ctrl3_q;
    pass4_q <= pass3_q;
    row_q   <= row_d;
  end

  assign push = v4_q && ctrl4_q.emit;
  assign res  = '{filtered: ctrl4_q.interior ? sat : pass4_q, frame_end: ctrl4_q.frame_end};

  gwc_fifo #(
    .DEPTH (gwc_pkg::OutDepth),
    .WIDTH (OW)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (res),
    .pop_i   (out_valid_o && out_ready_i),
    .rdata_o (ordata),
    .empty_o (oempty),
    .full_o  (ofull),
    .count_o (ocount)
  );

  assign out_valid_o = !oempty;
  assign out_item_o  = gwc_pkg::out_item_t'(ordata);

endmodule

// ===== hdl/gaussian_window_convolution.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | in_item_i (req_type, sample)
// out     | output    | out_valid_o/out_ready_i | out_item_o (filtered, frame_end)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per clock sustained while neither queue stalls; a result is offered once its item
// has passed the command queue, line store and ring read, window update, multiply, two add levels
// reset clears counters and queues; line stores and ring need no clearing
// the front stalls only on a full command queue; the back stalls only when the
// result queue plus items in flight reach its depth
module gaussian_window_convolution #(
  parameter int KERNEL_SIZE = gwc_pkg::KernelSizeDef,
  parameter int CHANNELS    = gwc_pkg::ChannelsDef,
  parameter int MAX_WIDTH   = gwc_pkg::MaxWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gwc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gwc_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = $clog2(MAX_WIDTH * CHANNELS);
  localparam int CTRLW = $bits(gwc_pkg::cmd_ctrl_t);
  localparam int CMDW  = CTRLW + CHW + AW;

  // configuration registers
  logic [10:0]      width_q;
  logic [15:0]      height_q;
  gwc_pkg::coeffs_t coeffs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gwc_pkg::WidthRst;
      height_q <= gwc_pkg::HeightRst;
      coeffs_q <= '{d0: gwc_pkg::CoeffD0Rst, d1: gwc_pkg::CoeffD1Rst,
                    d2: gwc_pkg::CoeffD2Rst, d4: gwc_pkg::CoeffD4Rst,
                    d5: gwc_pkg::CoeffD5Rst, d8: gwc_pkg::CoeffD8Rst};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gwc_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[10:0];
        gwc_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D0:     coeffs_q.d0 <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D1:     coeffs_q.d1 <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D2:     coeffs_q.d2 <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D4:     coeffs_q.d4 <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D5:     coeffs_q.d5 <= cfg_data_i;
        gwc_pkg::CFG_COEFF_D8:     coeffs_q.d8 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: position tracking and classification of each item
  logic               f_push, q_full, q_empty, b_pop;
  gwc_pkg::cmd_ctrl_t f_ctrl, b_ctrl;
  logic [CHW-1:0]     f_ch, b_ch;
  logic [AW-1:0]      f_addr, b_addr;
  logic [CMDW-1:0]    q_rdata;
  logic [$clog2(gwc_pkg::CmdDepth+1)-1:0] q_count;

  gwc_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .CHANNELS    (CHANNELS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cmd_ready_i  (!q_full),
    .cmd_push_o   (f_push),
    .cmd_ctrl_o   (f_ctrl),
    .cmd_ch_o     (f_ch),
    .cmd_addr_o   (f_addr)
  );

  // command queue between front and back
  gwc_fifo #(
    .DEPTH (gwc_pkg::CmdDepth),
    .WIDTH (CMDW)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_ctrl, f_ch, f_addr}),
    .pop_i   (b_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  assign b_ctrl = gwc_pkg::cmd_ctrl_t'(q_rdata[CMDW-1 -: CTRLW]);
  assign b_ch   = q_rdata[AW +: CHW];
  assign b_addr = q_rdata[AW-1:0];

  // back: line stores, window, weighted sum and result queue
  gwc_back #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .CHANNELS    (CHANNELS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty && (q_count != '0)),
    .cmd_pop_o   (b_pop),
    .cmd_ctrl_i  (b_ctrl),
    .cmd_ch_i    (b_ch),
    .cmd_addr_i  (b_addr),
    .coeffs_i    (coeffs_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
